FILE: hw/rtl/swaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swaf_pkg
// Shared types and constants of the sliding window anagram finder.
// ----------------------------------------------------------------------------
package swaf_pkg;

    // sizing
    localparam int MAX_PATTERN   = 64;
    localparam int POSITION_BITS = 16;
    localparam int ALPHABET      = 26;

    // field widths
    localparam int ACT_W   = 2;
    localparam int LTR_W   = 5;
    localparam int START_W = 16;

    // balance width and derived widths
    localparam int BAL_W   = 8;
    localparam int BAL_AW  = $clog2(ALPHABET);
    localparam int RING_AW = $clog2(MAX_PATTERN);
    localparam int PLEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int POS_W   = POSITION_BITS + 1;

    // action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_PATTERN = 2'd1,
        ACT_TEXT    = 2'd2
    } t_action;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PAT_UPD,
        S_TXT_DEC,
        S_TXT_LOOP,
        S_TXT_OLD,
        S_TXT_INC,
        S_TXT_FIN
    } t_state;

endpackage

FILE: hw/rtl/swaf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swaf_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface swaf_in_if
    import swaf_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [LTR_W-1:0] letter;

    modport source (output valid, output action, output letter, input ready);
    modport sink   (input valid, input action, input letter, output ready);
endinterface

interface swaf_out_if
    import swaf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [START_W-1:0] start_index;

    modport source (output valid, output start_index, input ready);
    modport sink   (input valid, input start_index, output ready);
endinterface

FILE: hw/rtl/sliding_window_anagram_finder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_anagram_finder_top
// Reports every text position where a permutation of the pattern begins.
// ----------------------------------------------------------------------------
// Items carry an action (clear, add pattern letter, feed text letter) and a
// letter code. A small sequencer drives one shared +/-1 adder over a balance
// RAM (pattern count minus window count per letter) and a ring RAM holding
// the window letters; both RAMs have one read port with a registered read.
// A clear, an ignored item or a dropped text letter stays in S_IDLE, a pattern
// letter passes S_PAT_UPD, and a text letter S_TXT_DEC, S_TXT_LOOP and
// S_TXT_FIN, with S_TXT_OLD, S_TXT_INC, S_TXT_LOOP per older letter pushed out
// of the window (no S_TXT_INC when it matches the new letter, only S_TXT_LOOP
// when the new letter itself is rejected); over a long text each letter leaves
// once. The balance table clears at once through per-letter valid bits; no
// clearing pass follows reset. A result is held in an output register and may
// wait while the next item is taken; a text letter whose result finds that
// register full waits in its last cycle until the earlier result is accepted.
// ----------------------------------------------------------------------------
module sliding_window_anagram_finder_top
    import swaf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    swaf_in_if.sink     i_in,
    swaf_out_if.source  o_out
);

    // control registers
    t_state                r_state, n_state;
    logic [ALPHABET-1:0]   r_bal_vld, n_bal_vld;
    logic [PLEN_W-1:0]     r_plen, n_plen;
    logic [POS_W-1:0]      r_start, n_start;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic                  r_out_vld, n_out_vld;

    // payload registers
    logic [BAL_AW-1:0]     r_ltr, n_ltr;
    logic [BAL_AW-1:0]     r_old, n_old;
    logic [BAL_W-1:0]      r_cur, n_cur;
    logic                  r_keep, n_keep;
    logic [START_W-1:0]    r_out_idx, n_out_idx;
    logic                  r_rd_vld;

    // ram ports
    logic                  bal_we;
    logic [BAL_AW-1:0]     bal_waddr, bal_raddr;
    logic [BAL_W-1:0]      bal_wdata, bal_rdata, bal_q;
    logic                  ring_we;
    logic [RING_AW-1:0]    ring_waddr, ring_raddr;
    logic [BAL_AW-1:0]     ring_wdata, ring_rdata;

    // shared adder
    logic [BAL_W-1:0]      add_a, add_sum;
    logic                  add_inc;

    logic                  ltr_ok;
    logic [BAL_AW-1:0]     in_ltr;
    logic [POS_W-1:0]      pos_inc, win_len;
    logic                  emit;

    swaf_ram #(.WIDTH(BAL_W), .DEPTH(ALPHABET)) u_bal_ram (
        .i_clk   (i_clk),
        .i_we    (bal_we),
        .i_waddr (bal_waddr),
        .i_wdata (bal_wdata),
        .i_raddr (bal_raddr),
        .o_rdata (bal_rdata)
    );

    swaf_ram #(.WIDTH(BAL_AW), .DEPTH(MAX_PATTERN)) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    // input decode and window bookkeeping
    assign ltr_ok  = 32'(i_in.letter) < ALPHABET;
    assign in_ltr  = BAL_AW'(i_in.letter);
    assign bal_q   = r_rd_vld ? bal_rdata : '0;
    assign add_sum = add_a + (add_inc ? BAL_W'(1) : {BAL_W{1'b1}});
    assign pos_inc = r_pos + POS_W'(1);
    assign win_len = pos_inc - r_start;
    assign emit    = win_len == POS_W'(r_plen);

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_vld;
    assign o_out.start_index = r_out_idx;

    // sequencer: next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_bal_vld = r_bal_vld;
        n_plen    = r_plen;
        n_start   = r_start;
        n_pos     = r_pos;
        n_out_vld = r_out_vld && !o_out.ready;
        n_ltr     = r_ltr;
        n_old     = r_old;
        n_cur     = r_cur;
        n_keep    = r_keep;
        n_out_idx = r_out_idx;

        bal_we     = 1'b0;
        bal_waddr  = r_ltr;
        bal_wdata  = add_sum;
        bal_raddr  = in_ltr;
        ring_we    = 1'b0;
        ring_waddr = r_pos[RING_AW-1:0];
        ring_wdata = r_ltr;
        ring_raddr = r_start[RING_AW-1:0];
        add_a      = bal_q;
        add_inc    = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    case (i_in.action)
                        ACT_CLEAR: begin
                            n_bal_vld = '0;
                            n_plen    = '0;
                            n_start   = '0;
                            n_pos     = '0;
                        end
                        ACT_PATTERN: begin
                            if (ltr_ok && r_pos == '0 && 32'(r_plen) < MAX_PATTERN) begin
                                n_ltr   = in_ltr;
                                n_state = S_PAT_UPD;
                            end
                        end
                        ACT_TEXT: begin
                            if (ltr_ok && !r_pos[POS_W-1]) begin
                                n_ltr   = in_ltr;
                                n_keep  = 1'b1;
                                n_state = S_TXT_DEC;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PAT_UPD: begin
                bal_we  = 1'b1;
                n_plen  = r_plen + PLEN_W'(1);
                n_state = S_IDLE;
            end
            S_TXT_DEC: begin
                add_inc = 1'b0;
                n_cur   = add_sum;
                n_state = S_TXT_LOOP;
            end
            S_TXT_LOOP: begin
                if (!r_cur[BAL_W-1]) begin
                    bal_we    = 1'b1;
                    bal_wdata = r_cur;
                    n_state   = S_TXT_FIN;
                end else if (r_start < r_pos) begin
                    n_state = S_TXT_OLD;
                end else begin
                    // the new letter is rejected at once
                    add_a   = r_cur;
                    n_cur   = add_sum;
                    n_start = r_start + POS_W'(1);
                    n_keep  = 1'b0;
                end
            end
            S_TXT_OLD: begin
                if (ring_rdata == r_ltr) begin
                    add_a   = r_cur;
                    n_cur   = add_sum;
                    n_start = r_start + POS_W'(1);
                    n_state = S_TXT_LOOP;
                end else begin
                    bal_raddr = ring_rdata;
                    n_old     = ring_rdata;
                    n_state   = S_TXT_INC;
                end
            end
            S_TXT_INC: begin
                bal_we    = 1'b1;
                bal_waddr = r_old;
                n_start   = r_start + POS_W'(1);
                n_state   = S_TXT_LOOP;
            end
            S_TXT_FIN: begin
                if (!emit || !r_out_vld || o_out.ready) begin
                    ring_we = r_keep;
                    n_pos   = pos_inc;
                    if (emit) begin
                        n_out_vld = 1'b1;
                        n_out_idx = START_W'(r_start[POSITION_BITS-1:0]);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a written letter reads back its stored balance
        if (bal_we) begin
            n_bal_vld[bal_waddr] = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bal_vld <= '0;
            r_plen    <= '0;
            r_start   <= '0;
            r_pos     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bal_vld <= n_bal_vld;
            r_plen    <= n_plen;
            r_start   <= n_start;
            r_pos     <= n_pos;
            r_out_vld <= n_out_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_ltr     <= n_ltr;
        r_old     <= n_old;
        r_cur     <= n_cur;
        r_keep    <= n_keep;
        r_out_idx <= n_out_idx;
        r_rd_vld  <= r_bal_vld[bal_raddr];
    end

endmodule

FILE: hw/rtl/swaf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swaf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module swaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
